// ----- rtl/core/normal_map_pixel_shade_defines.svh -----
// Assertion macros for the normal map pixel shader.
`ifndef NORMAL_MAP_PIXEL_SHADE_DEFINES_SVH
`define NORMAL_MAP_PIXEL_SHADE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every clock edge outside reset.
`define NMPS_ASSERT_IMPL(name, lhs, rhs) \
  name: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Next-cycle implication, checked on every clock edge outside reset.
`define NMPS_ASSERT_NEXT(name, lhs, rhs) \
  name: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`else
`define NMPS_ASSERT_IMPL(name, lhs, rhs)
`define NMPS_ASSERT_NEXT(name, lhs, rhs)
`endif

`endif

// ----- rtl/core/nmps_pkg.sv -----
// Shared constants and types for the normal map pixel shader.
package nmps_pkg;

  localparam int LIGHT_FRAC_BITS = 14;
  localparam int LIGHT_W = 16;
  localparam int CODE_W = 8;
  localparam int CH_W = 8;
  localparam int NRM_W = 9;
  localparam int SUMSQ_W = 18;
  localparam int PROD_W = NRM_W + LIGHT_W;
  localparam int ZTERM_W = CODE_W + LIGHT_FRAC_BITS;
  localparam int DOT_W = ((PROD_W > ZTERM_W + 1) ? PROD_W : ZTERM_W + 1) + 2;
  localparam int P_W = DOT_W - 1;
  localparam int PP_W = 2 * P_W;
  localparam int ROOT_W = P_W;

  localparam logic [LIGHT_W-1:0] LIGHT_RESET = 16'hF333;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } color_t;

  typedef struct packed {
    logic   valid;
    color_t color;
  } side_t;

endpackage

// ----- rtl/core/nmps_in_if.sv -----
// Input pixel channel: base color and normal map texel.
interface nmps_in_if;
  import nmps_pkg::*;
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   base_red;
  logic [CH_W-1:0]   base_green;
  logic [CH_W-1:0]   base_blue;
  logic [CH_W-1:0]   base_alpha;
  logic [CODE_W-1:0] normal_x_code;
  logic [CODE_W-1:0] normal_y_code;
  logic [CODE_W-1:0] normal_z_code;

  modport source (output valid, base_red, base_green, base_blue, base_alpha,
                  normal_x_code, normal_y_code, normal_z_code, input ready);
  modport sink (input valid, base_red, base_green, base_blue, base_alpha,
                normal_x_code, normal_y_code, normal_z_code, output ready);
endinterface

// ----- rtl/core/nmps_out_if.sv -----
// Output pixel channel: shaded color.
interface nmps_out_if;
  import nmps_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] shade_red;
  logic [CH_W-1:0] shade_green;
  logic [CH_W-1:0] shade_blue;
  logic [CH_W-1:0] shade_alpha;

  modport source (output valid, shade_red, shade_green, shade_blue, shade_alpha,
                  input ready);
  modport sink (input valid, shade_red, shade_green, shade_blue, shade_alpha,
                output ready);
endinterface

// ----- rtl/core/nmps_front.sv -----
// Front stages: decode normal, dot with light, sum of squares, square of dot.
module nmps_front import nmps_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  side_t                      side_in,
  input  logic [CODE_W-1:0]          x_code,
  input  logic [CODE_W-1:0]          y_code,
  input  logic [CODE_W-1:0]          z_code,
  input  logic signed [LIGHT_W-1:0]  light_x,
  input  logic signed [LIGHT_W-1:0]  light_y,
  output side_t                      side_out,
  output logic [PP_W-1:0]            pp,
  output logic [SUMSQ_W-1:0]         sumsq
);

  logic signed [NRM_W:0]   nx_wide, ny_wide;
  logic signed [NRM_W-1:0] nx, ny;

  side_t                    side1, side2;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic [ZTERM_W-1:0]       zterm;
  logic [SUMSQ_W-1:0]       sq_x, sq_y, sq_z;
  logic signed [DOT_W-1:0]  dot;
  logic [P_W-1:0]           p;
  logic [SUMSQ_W-1:0]       sumsq2;

  // Decode 2v-255 as 2v+1-256
  assign nx_wide = $signed({1'b0, x_code, 1'b1}) - $signed({1'b0, 1'b1, {CODE_W{1'b0}}});
  assign ny_wide = $signed({1'b0, y_code, 1'b1}) - $signed({1'b0, 1'b1, {CODE_W{1'b0}}});
  assign nx = nx_wide[NRM_W-1:0];
  assign ny = ny_wide[NRM_W-1:0];

  // Stage one: products and squares
  always_ff @(posedge clk) begin
    if (rst) begin
      side1.valid <= 1'b0;
    end else if (en) begin
      side1.valid <= side_in.valid;
    end
    if (en) begin
      side1.color <= side_in.color;
      prod_x <= nx * light_x;
      prod_y <= ny * light_y;
      zterm  <= {z_code, {LIGHT_FRAC_BITS{1'b0}}};
      sq_x   <= SUMSQ_W'(nx * nx);
      sq_y   <= SUMSQ_W'(ny * ny);
      sq_z   <= SUMSQ_W'(z_code * z_code);
    end
  end

  // Stage two: dot product clamped at zero, sum of squares
  assign dot = DOT_W'(prod_x) + DOT_W'(prod_y) + $signed(DOT_W'(zterm));

  always_ff @(posedge clk) begin
    if (rst) begin
      side2.valid <= 1'b0;
    end else if (en) begin
      side2.valid <= side1.valid;
    end
    if (en) begin
      side2.color <= side1.color;
      p      <= (dot > 0) ? dot[P_W-1:0] : '0;
      sumsq2 <= sq_x + sq_y + sq_z;
    end
  end

  // Stage three: square of the dot product
  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (en) begin
      side_out.valid <= side2.valid;
    end
    if (en) begin
      side_out.color <= side2.color;
      pp    <= p * p;
      sumsq <= sumsq2;
    end
  end

endmodule

// ----- rtl/core/nmps_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module nmps_div import nmps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  side_t              side_in,
  input  logic [PP_W-1:0]    dividend,
  input  logic [SUMSQ_W-1:0] divisor,
  output side_t              side_out,
  output logic [PP_W-1:0]    quotient
);

  side_t              side [0:PP_W];
  logic [PP_W-1:0]    dvd  [0:PP_W];
  logic [SUMSQ_W-1:0] rem  [0:PP_W];
  logic [SUMSQ_W-1:0] dsr  [0:PP_W];

  assign side[0] = side_in;
  assign dvd[0]  = dividend;
  assign rem[0]  = '0;
  assign dsr[0]  = divisor;

  for (genvar k = 0; k < PP_W; k++) begin : g_stage
    logic [SUMSQ_W:0] shifted;
    logic [SUMSQ_W:0] diff;
    logic             ge;

    // Shift in the next dividend bit and try a subtract
    assign shifted = {rem[k], dvd[k][PP_W-1]};
    assign diff    = shifted - {1'b0, dsr[k]};
    assign ge      = shifted >= {1'b0, dsr[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        side[k+1].valid <= 1'b0;
      end else if (en) begin
        side[k+1].valid <= side[k].valid;
      end
      if (en) begin
        side[k+1].color <= side[k].color;
        dsr[k+1] <= dsr[k];
        dvd[k+1] <= {dvd[k][PP_W-2:0], ge};
        rem[k+1] <= ge ? diff[SUMSQ_W-1:0] : shifted[SUMSQ_W-1:0];
      end
    end
  end

  assign side_out = side[PP_W];
  assign quotient = dvd[PP_W];

endmodule

// ----- rtl/core/nmps_sqrt.sv -----
// Pipelined integer square root, one root bit per stage.
module nmps_sqrt import nmps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  side_t             side_in,
  input  logic [PP_W-1:0]   radicand,
  output side_t             side_out,
  output logic [ROOT_W-1:0] root
);

  localparam int RW = ROOT_W + 2;

  side_t             side [0:ROOT_W];
  logic [PP_W-1:0]   rad  [0:ROOT_W];
  logic [RW-1:0]     rem  [0:ROOT_W];
  logic [ROOT_W-1:0] rt   [0:ROOT_W];

  assign side[0] = side_in;
  assign rad[0]  = radicand;
  assign rem[0]  = '0;
  assign rt[0]   = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [RW-1:0] shifted;
    logic [RW-1:0] trial;
    logic          ge;

    // Bring down two radicand bits and test against 4*root+1
    assign shifted = {rem[k][RW-3:0], rad[k][PP_W-1:PP_W-2]};
    assign trial   = {rt[k], 2'b01};
    assign ge      = shifted >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        side[k+1].valid <= 1'b0;
      end else if (en) begin
        side[k+1].valid <= side[k].valid;
      end
      if (en) begin
        side[k+1].color <= side[k].color;
        rad[k+1] <= {rad[k][PP_W-3:0], 2'b00};
        rem[k+1] <= ge ? shifted - trial : shifted;
        rt[k+1]  <= {rt[k][ROOT_W-2:0], ge};
      end
    end
  end

  assign side_out = side[ROOT_W];
  assign root     = rt[ROOT_W];

endmodule

// ----- rtl/core/nmps_shade.sv -----
// Channel scaling by intensity with saturation, and the output register.
module nmps_shade import nmps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  side_t             side_in,
  input  logic [ROOT_W-1:0] inten,
  output side_t             side_out,
  output logic [CH_W-1:0]   red,
  output logic [CH_W-1:0]   green,
  output logic [CH_W-1:0]   blue
);

  localparam int MUL_W = CH_W + ROOT_W;

  side_t            side1;
  logic [MUL_W-1:0] mul_r, mul_g, mul_b;

  function automatic logic [CH_W-1:0] sat(input logic [MUL_W-1:0] m);
    logic [MUL_W-1:0] s;
    s = m >> LIGHT_FRAC_BITS;
    return (s > MUL_W'(2 ** CH_W - 1)) ? {CH_W{1'b1}} : s[CH_W-1:0];
  endfunction

  // Multiply each channel by the intensity
  always_ff @(posedge clk) begin
    if (rst) begin
      side1.valid <= 1'b0;
    end else if (en) begin
      side1.valid <= side_in.valid;
    end
    if (en) begin
      side1.color <= side_in.color;
      mul_r <= side_in.color.red * inten;
      mul_g <= side_in.color.green * inten;
      mul_b <= side_in.color.blue * inten;
    end
  end

  // Scale down, saturate and hold for the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (en) begin
      side_out.valid <= side1.valid;
    end
    if (en) begin
      side_out.color <= side1.color;
      red   <= sat(mul_r);
      green <= sat(mul_g);
      blue  <= sat(mul_b);
    end
  end

endmodule

// ----- rtl/core/normal_map_pixel_shade.sv -----
// Top level of the normal map pixel shader.
//
//   channel   dir  handshake     payload
//   pix_in    in   valid/ready   base RGBA, normal x/y/z codes
//   pix_out   out  valid/ready   shaded RGBA
//   cfg       in   cfg_we        cfg_index, cfg_data (light x, light y)
//
// One pixel per cycle sustained while pix_out takes results. The clamped
// dot product is P = 26 bits at 14 fraction bits; the divider takes one
// quotient bit and the square root one root bit per stage.
// Reset clears all valid bits and loads the light registers.
// A stall at pix_out freezes the whole pipeline; pix_in.ready follows it.
`include "normal_map_pixel_shade_defines.svh"

module normal_map_pixel_shade import nmps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  nmps_in_if.sink            pix_in,
  nmps_out_if.source         pix_out,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [LIGHT_W-1:0] cfg_data
);

  typedef enum logic {
    REG_LIGHT_X = 1'b0,
    REG_LIGHT_Y = 1'b1
  } reg_index_t;

  logic [LIGHT_W-1:0] light_x, light_y;
  logic               en;
  side_t              side_in, side_front, side_div, side_sqrt, side_out;
  logic [PP_W-1:0]    pp, quot;
  logic [SUMSQ_W-1:0] sumsq;
  logic [ROOT_W-1:0]  inten;

  // Hold light direction registers
  always_ff @(posedge clk) begin
    if (rst) begin
      light_x <= LIGHT_RESET;
      light_y <= LIGHT_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_LIGHT_X: light_x <= cfg_data;
        REG_LIGHT_Y: light_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the pipeline unless the output holds an untaken transfer
  assign en           = !side_out.valid || pix_out.ready;
  assign pix_in.ready = en;

  assign side_in.valid       = pix_in.valid;
  assign side_in.color.red   = pix_in.base_red;
  assign side_in.color.green = pix_in.base_green;
  assign side_in.color.blue  = pix_in.base_blue;
  assign side_in.color.alpha = pix_in.base_alpha;

  nmps_front u_front (
    .clk, .rst, .en,
    .side_in,
    .x_code   (pix_in.normal_x_code),
    .y_code   (pix_in.normal_y_code),
    .z_code   (pix_in.normal_z_code),
    .light_x  ($signed(light_x)),
    .light_y  ($signed(light_y)),
    .side_out (side_front),
    .pp,
    .sumsq
  );

  nmps_div u_div (
    .clk, .rst, .en,
    .side_in  (side_front),
    .dividend (pp),
    .divisor  (sumsq),
    .side_out (side_div),
    .quotient (quot)
  );

  nmps_sqrt u_sqrt (
    .clk, .rst, .en,
    .side_in  (side_div),
    .radicand (quot),
    .side_out (side_sqrt),
    .root     (inten)
  );

  nmps_shade u_shade (
    .clk, .rst, .en,
    .side_in  (side_sqrt),
    .inten,
    .side_out,
    .red      (pix_out.shade_red),
    .green    (pix_out.shade_green),
    .blue     (pix_out.shade_blue)
  );

  assign pix_out.valid       = side_out.valid;
  assign pix_out.shade_alpha = side_out.color.alpha;

  // A waiting result blocks new input
  `NMPS_ASSERT_IMPL(a_stall_blocks_input, pix_out.valid && !pix_out.ready, !pix_in.ready)
  // A stall freezes the intensity stage
  `NMPS_ASSERT_NEXT(a_stall_freezes_root, !en, $stable(inten) && $stable(side_sqrt.valid))
  // Alpha of a waiting result stays put
  `NMPS_ASSERT_NEXT(a_stall_holds_alpha, !en, $stable(side_out.color.alpha))

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the normal map pixel shader: random traffic, light sweeps.
module tb_top;
  import nmps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] r, g, b, a, nx, ny, nz;
  } texel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [LIGHT_W-1:0] cfg_data = '0;

  localparam logic REG_LIGHT_X = 1'b0;
  localparam logic REG_LIGHT_Y = 1'b1;

  nmps_in_if pix_in();
  nmps_out_if pix_out();

  normal_map_pixel_shade dut (
    .clk(clk), .rst(rst), .pix_in(pix_in.sink), .pix_out(pix_out.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  texel_t pending_texels[$];
  color_t expected_colors[$];
  logic signed [15:0] light_x = LIGHT_RESET;
  logic signed [15:0] light_y = LIGHT_RESET;
  int errors = 0;
  int accepted = 0;
  bit quiet = 0;
  bit done_feeding = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Integer square root by the digit-by-digit method.
  function automatic longint unsigned root_of(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [7:0] scale_channel(logic [7:0] base, longint unsigned inten);
    longint unsigned c;
    c = (longint'(base) * inten) >> LIGHT_FRAC_BITS;
    return (c > 255) ? 8'd255 : c[7:0];
  endfunction

  // Shade one texel with the current light setting.
  function automatic color_t shade_texel(texel_t t);
    longint x, y, z, dot;
    longint unsigned sumsq, p, inten;
    color_t c;
    x = 2 * longint'(t.nx) - 255;
    y = 2 * longint'(t.ny) - 255;
    z = longint'(t.nz);
    sumsq = x * x + y * y + z * z;
    dot = x * longint'(light_x) + y * longint'(light_y) + z * (longint'(1) << LIGHT_FRAC_BITS);
    inten = 0;
    if (dot > 0) begin
      p = dot;
      inten = root_of((p * p) / sumsq);
    end
    c.red = scale_channel(t.r, inten);
    c.green = scale_channel(t.g, inten);
    c.blue = scale_channel(t.b, inten);
    c.alpha = t.a;
    return c;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  // Driver: offer pending texels with random idle bursts.
  texel_t cur;
  int src_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      pix_in.valid <= 1'b0;
      pix_in.base_red <= '0;
      pix_in.base_green <= '0;
      pix_in.base_blue <= '0;
      pix_in.base_alpha <= '0;
      pix_in.normal_x_code <= '0;
      pix_in.normal_y_code <= '0;
      pix_in.normal_z_code <= '0;
    end else begin
      if (pix_in.valid && pix_in.ready) begin
        expected_colors.push_back(shade_texel(cur));
        accepted++;
      end
      if (!pix_in.valid || pix_in.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          pix_in.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          src_gap = $urandom_range(1, 14) - 1;
          pix_in.valid <= 1'b0;
        end else if (pending_texels.size() > 0) begin
          cur = pending_texels.pop_front();
          pix_in.valid <= 1'b1;
          pix_in.base_red <= cur.r;
          pix_in.base_green <= cur.g;
          pix_in.base_blue <= cur.b;
          pix_in.base_alpha <= cur.a;
          pix_in.normal_x_code <= cur.nx;
          pix_in.normal_y_code <= cur.ny;
          pix_in.normal_z_code <= cur.nz;
        end else begin
          pix_in.valid <= 1'b0;
        end
      end
    end
  end

  // Hold off the receiver once for a long stretch after enough transfers.
  int hold_left = 0;
  bit held = 0;
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!held && accepted >= 400) begin
      held <= 1'b1;
      hold_left <= 300;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: random stalls, one long hold-off, compare each transfer.
  int sink_gap = 0;
  color_t want;
  always @(posedge clk) begin
    if (rst) begin
      pix_out.ready <= 1'b0;
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        if (expected_colors.size() == 0) begin
          $display("unexpected output pixel");
          errors++;
        end else begin
          want = expected_colors.pop_front();
          if (pix_out.shade_red !== want.red) report_mismatch("red", pix_out.shade_red, want.red);
          if (pix_out.shade_green !== want.green)
            report_mismatch("green", pix_out.shade_green, want.green);
          if (pix_out.shade_blue !== want.blue)
            report_mismatch("blue", pix_out.shade_blue, want.blue);
          if (pix_out.shade_alpha !== want.alpha)
            report_mismatch("alpha", pix_out.shade_alpha, want.alpha);
        end
      end
      if (hold_left > 0) begin
        pix_out.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        pix_out.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        sink_gap = $urandom_range(1, 14) - 1;
        pix_out.ready <= 1'b0;
      end else begin
        pix_out.ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'(8'd127 + $urandom_range(0, 2));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_texel(logic [7:0] r, g, b, a, nx, ny, nz);
    texel_t t;
    t = '{r: r, g: g, b: b, a: a, nx: nx, ny: ny, nz: nz};
    pending_texels.push_back(t);
  endtask

  task automatic add_random(int n);
    repeat (n) add_texel(pick_code(), pick_code(), pick_code(), 8'($urandom_range(0, 255)),
                         pick_code(), pick_code(), pick_code());
  endtask

  // Hold until the block has drained every transfer.
  task automatic wait_idle();
    while (pending_texels.size() != 0 || expected_colors.size() != 0 || pix_in.valid)
      @(posedge clk);
  endtask

  task automatic write_light(logic idx, logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    if (idx == REG_LIGHT_X) light_x = v; else light_y = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  logic [15:0] light_set[6][2] = '{
    '{16'h0000, 16'h0000}, '{16'h7FFF, 16'h7FFF}, '{16'h8000, 16'h8000},
    '{16'h8000, 16'h7FFF}, '{16'h7FFF, 16'h8000}, '{16'h4000, 16'hC000}
  };

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // directed: flat, tilted, behind, saturating, zero blue byte
    add_texel(255, 255, 255, 255, 128, 128, 255);
    add_texel(0, 0, 0, 0, 128, 128, 255);
    add_texel(255, 128, 1, 77, 255, 255, 255);
    add_texel(200, 100, 50, 9, 0, 0, 0);
    add_texel(255, 255, 255, 170, 255, 255, 0);
    add_texel(255, 255, 255, 85, 0, 0, 255);
    add_texel(1, 2, 3, 4, 255, 0, 128);
    add_texel(255, 0, 255, 0, 127, 128, 1);
    add_texel(170, 85, 170, 85, 0, 255, 200);
    wait_idle();
    write_light(REG_LIGHT_X, 16'h8000);
    write_light(REG_LIGHT_Y, 16'h8000);
    add_texel(255, 255, 255, 255, 0, 0, 10);
    add_texel(255, 255, 255, 255, 255, 255, 0);
    add_texel(255, 255, 255, 1, 0, 0, 0);
    add_texel(255, 255, 255, 2, 255, 255, 255);
    wait_idle();
    write_light(REG_LIGHT_X, 16'h7FFF);
    write_light(REG_LIGHT_Y, 16'h7FFF);
    add_texel(255, 255, 255, 3, 255, 255, 255);
    add_texel(255, 255, 255, 4, 0, 0, 255);
    add_texel(128, 64, 32, 5, 200, 200, 20);
    add_random(600);
    foreach (light_set[i]) begin
      wait_idle();
      write_light(REG_LIGHT_X, light_set[i][0]);
      write_light(REG_LIGHT_Y, light_set[i][1]);
      add_random(150);
    end
    repeat (3) begin
      wait_idle();
      write_light(REG_LIGHT_X, 16'($urandom_range(0, 65535)));
      write_light(REG_LIGHT_Y, 16'($urandom_range(0, 65535)));
      add_random(100);
    end
    wait_idle();
    quiet = 1;
    write_light(REG_LIGHT_X, 16'($urandom_range(0, 65535)));
    write_light(REG_LIGHT_Y, 16'($urandom_range(0, 65535)));
    add_random(50);
    wait_idle();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_colors.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end
endmodule
